@@ design/wbss_pkg.sv @@
package wbss_pkg;

	// fixed field widths
	localparam int SIG_BYTES = 16;
	localparam int ADDR_W    = 48;
	localparam int LEN_W     = 5;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int MASK_W    = 16;

	// signature bytes, byte 0 in the lowest eight bits
	typedef logic [SIG_BYTES-1:0][7:0] sig_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LO = 3'd0,
		REG_PAT_HI = 3'd1,
		REG_MASK   = 3'd2,
		REG_LEN    = 3'd3,
		REG_BASE   = 3'd4
	} cfg_reg_t;

	// one scan result handed to the output stage
	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] match_address;
	} result_t;

endpackage

@@ design/wbss_window.sv @@
module wbss_window #(
	parameter int LEN_CAP = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift_en,
	input  logic                       clear,
	input  logic [7:0]                 data_byte,
	input  logic                       byte_readable,
	input  wbss_pkg::sig_t             pattern,
	input  logic [wbss_pkg::MASK_W-1:0] mask,
	input  logic [wbss_pkg::LEN_W-1:0] len,
	output logic                       match
);
	import wbss_pkg::*;

	logic [7:0]         win_q [LEN_CAP];
	logic [LEN_CAP-1:0] rd_q;
	logic [7:0]         cur_byte [LEN_CAP];
	logic [LEN_CAP-1:0] cur_rd;

	// window as it stands once the new byte is shifted in
	always_comb begin
		cur_byte[0] = data_byte;
		cur_rd[0]   = byte_readable;
		for (int p = 1; p < LEN_CAP; p++) begin
			cur_byte[p] = win_q[p-1];
			cur_rd[p]   = rd_q[p-1];
		end
	end

	// parallel compare, position p checks signature byte len-1-p
	always_comb begin
		logic [LEN_W-1:0] k;
		match = 1'b1;
		k     = '0;
		for (int p = 0; p < LEN_CAP; p++) begin
			if (LEN_W'(p) < len) begin
				k = len - LEN_W'(p) - LEN_W'(1);
				if (!cur_rd[p]) begin
					match = 1'b0;
				end else if (!mask[k[3:0]] && (cur_byte[p] != pattern[k[3:0]])) begin
					match = 1'b0;
				end
			end
		end
	end

	// byte shift line
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < LEN_CAP; i++) begin
				win_q[i] <= cur_byte[i];
			end
		end
	end

	// readable flags, cleared at the end of a scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
		end else if (shift_en) begin
			if (clear) begin
				rd_q <= '0;
			end else begin
				rd_q <= cur_rd;
			end
		end
	end

endmodule

@@ design/wbss_result.sv @@
module wbss_result (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  wbss_pkg::result_t           res,
	input  logic                        m_tready,
	output logic                        m_tvalid,
	output logic [wbss_pkg::ADDR_W-1:0] m_tdata,
	output logic                        m_tuser,
	output logic                        take_ok
);
	import wbss_pkg::*;

	logic    valid_q;
	logic    spare_valid_q;
	result_t res_q;
	result_t spare_q;

	// input side only looks at the spare slot, so its ready is a register
	assign take_ok  = !spare_valid_q;
	assign m_tvalid = valid_q;
	assign m_tdata  = res_q.match_address;
	assign m_tuser  = res_q.found;

	// output and spare valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (valid_q && m_tready) begin
			if (spare_valid_q) begin
				spare_valid_q <= 1'b0;
			end else begin
				valid_q <= load;
			end
		end else if (load) begin
			if (valid_q) begin
				spare_valid_q <= 1'b1;
			end else begin
				valid_q <= 1'b1;
			end
		end
	end

	// output and spare payload
	always_ff @(posedge clk) begin
		if (valid_q && m_tready) begin
			if (spare_valid_q) begin
				res_q <= spare_q;
			end else if (load) begin
				res_q <= res;
			end
		end else if (load) begin
			if (valid_q) begin
				spare_q <= res;
			end else begin
				res_q <= res;
			end
		end
	end

endmodule

@@ design/wildcard_byte_signature_scan_unit.sv @@
// a result is registered on the output, or in the spare register while the output holds one, when its byte is taken
// throughput: one byte per cycle; the input stalls only while two results wait,
// one on the output and one in the spare register behind it
// the window compare runs in parallel on the incoming byte and the stored window
// reset: arst_n clears the scan state, the output valid and the configuration registers
// (pattern length resets to one, all other registers to zero)
module wildcard_byte_signature_scan_unit #(
	parameter int MAX_PATTERN_BYTES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // data_byte
	input  logic                           s_axis_tuser,  // byte_readable
	input  logic                           s_axis_tlast,  // last_byte
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [wbss_pkg::ADDR_W-1:0]    m_axis_tdata,  // match_address
	output logic                           m_axis_tuser,  // found
	input  logic                           cfg_wen,
	input  logic [wbss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wbss_pkg::CFG_W-1:0]     cfg_wdata
);
	import wbss_pkg::*;

	localparam int LEN_CAP = (MAX_PATTERN_BYTES < SIG_BYTES) ? MAX_PATTERN_BYTES : SIG_BYTES;

	logic [63:0]       pat_lo_q;
	logic [63:0]       pat_hi_q;
	logic [MASK_W-1:0] mask_q;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] seen_q;
	logic              reported_q;

	logic [LEN_W-1:0]  len_eff;
	logic [ADDR_W-1:0] seen_nxt;
	logic              accept;
	logic              match;
	logic              hit;
	logic              emit;
	logic              take_ok;
	result_t           res;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			mask_q   <= '0;
			len_q    <= LEN_W'(1);
			base_q   <= '0;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_PAT_LO: pat_lo_q <= cfg_wdata;
				REG_PAT_HI: pat_hi_q <= cfg_wdata;
				REG_MASK:   mask_q   <= cfg_wdata[MASK_W-1:0];
				REG_LEN:    len_q    <= cfg_wdata[LEN_W-1:0];
				REG_BASE:   base_q   <= cfg_wdata[ADDR_W-1:0];
				default:    ;
			endcase
		end
	end

	// length in use, zero taken as one, capped at the window size
	always_comb begin
		len_eff = len_q;
		if (len_eff == '0) begin
			len_eff = LEN_W'(1);
		end
		if (len_eff > LEN_W'(LEN_CAP)) begin
			len_eff = LEN_W'(LEN_CAP);
		end
	end

	assign s_axis_tready = take_ok;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign seen_nxt      = seen_q + ADDR_W'(1);

	wbss_window #(
		.LEN_CAP(LEN_CAP)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.shift_en     (accept),
		.clear        (s_axis_tlast),
		.data_byte    (s_axis_tdata),
		.byte_readable(s_axis_tuser),
		.pattern      (sig_t'({pat_hi_q, pat_lo_q})),
		.mask         (mask_q),
		.len          (len_eff),
		.match        (match)
	);

	// result decision for the request being taken
	assign hit  = !reported_q && match;
	assign emit = accept && (hit || (s_axis_tlast && !reported_q));

	always_comb begin
		res.found         = hit;
		res.match_address = '0;
		if (hit) begin
			res.match_address = base_q + seen_nxt - ADDR_W'(len_eff);
		end
	end

	// scan progress, reset at the end of each region
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				seen_q     <= '0;
				reported_q <= 1'b0;
			end else begin
				seen_q <= seen_nxt;
				if (hit) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	wbss_result u_result (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (emit),
		.res     (res),
		.m_tready(m_axis_tready),
		.m_tvalid(m_axis_tvalid),
		.m_tdata (m_axis_tdata),
		.m_tuser (m_axis_tuser),
		.take_ok (take_ok)
	);

	// a not-found result carries address zero
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("not-found result with nonzero address");

	// the end of a region restarts the byte count and match flag
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_axis_tlast |=> seen_q == '0 && !reported_q)
		else $error("scan state not cleared after last byte");

	// once a match is reported no further result comes in that region
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		reported_q |-> !emit)
		else $error("second result in one scan");

	// a stalled input means a result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled without a waiting result");

endmodule

@@ test/wildcard_byte_signature_scan_unit_test.sv @@
`timescale 1ns / 1ps

module wildcard_byte_signature_scan_unit_test;
	import wbss_pkg::*;

	localparam int WIN          = 16;
	localparam int RANDOM_BYTES = 1600;

	typedef enum logic [1:0] {ROW_CFG, ROW_BYTE, ROW_QUIET, ROW_HIT} row_kind_t;

	// one directed step: a register write, or a byte with or without a typed-in result
	typedef struct {
		row_kind_t         kind;
		cfg_reg_t          reg_idx;
		logic [CFG_W-1:0]  value;
		logic [7:0]        data;
		bit                readable;
		bit                last;
		result_t           want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;  // data_byte
	logic                 s_axis_tuser;  // byte_readable
	logic                 s_axis_tlast;  // last_byte
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [ADDR_W-1:0]    m_axis_tdata;  // match_address
	logic                 m_axis_tuser;  // found
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	always #6 clk = ~clk;

	wildcard_byte_signature_scan_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	// scanner copy: sliding window, newest byte at 0
	logic [7:0]          win_byte [WIN];
	bit                  win_ok [WIN];
	logic [ADDR_W-1:0]   bytes_taken;
	bit                  scan_matched;

	// register copy
	logic [2*CFG_W-1:0]  sig_bytes   = '0;
	logic [MASK_W-1:0]   wild_bits   = '0;
	logic [LEN_W-1:0]    sig_len     = LEN_W'(1);
	logic [ADDR_W-1:0]   region_base = '0;

	result_t pending_results[$];

	int errors        = 0;
	int bytes_sent    = 0;
	int scans_ended   = 0;
	int hits_seen     = 0;
	int misses_seen   = 0;
	int settings_used = 0;
	bit calm          = 1'b0;
	bit cfg_busy      = 1'b0;

	// length in use: zero acts as one, saturates at the window size
	function automatic int used_len();
		if (sig_len == 0) return 1;
		if (sig_len > WIN) return WIN;
		return int'(sig_len);
	endfunction

	function automatic void clear_window();
		foreach (win_byte[i]) begin
			win_byte[i] = 8'h00;
			win_ok[i]   = 1'b0;
		end
		bytes_taken  = '0;
		scan_matched = 1'b0;
	endfunction

	function automatic void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
		case (idx)
			REG_PAT_LO: sig_bytes[CFG_W-1:0] = v;
			REG_PAT_HI: sig_bytes[2*CFG_W-1:CFG_W] = v;
			REG_MASK:   wild_bits = v[MASK_W-1:0];
			REG_LEN:    sig_len = v[LEN_W-1:0];
			REG_BASE:   region_base = v[ADDR_W-1:0];
			default:    ;
		endcase
	endfunction

	// shift one byte into the window and work out the scan result it causes
	function automatic bit scan_byte(input logic [7:0] b, input bit rd, input bit lst,
			output result_t r);
		int n;
		int i;
		int pos;
		bit hit;
		bit got;
		n   = used_len();
		hit = 1'b1;
		got = 1'b0;
		r   = '0;
		for (i = WIN - 1; i > 0; i--) begin
			win_byte[i] = win_byte[i-1];
			win_ok[i]   = win_ok[i-1];
		end
		win_byte[0] = b;
		win_ok[0]   = rd;
		bytes_taken = bytes_taken + ADDR_W'(1);
		// signature byte 0 lines up with the oldest byte of the window
		for (i = 0; i < n; i++) begin
			pos = n - 1 - i;
			if (!win_ok[pos])
				hit = 1'b0;
			else if (!wild_bits[i] && win_byte[pos] != sig_bytes[i*8 +: 8])
				hit = 1'b0;
		end
		if (!scan_matched && hit) begin
			r.found         = 1'b1;
			r.match_address = region_base + bytes_taken - ADDR_W'(n);
			scan_matched    = 1'b1;
			got             = 1'b1;
		end else if (lst && !scan_matched) begin
			got = 1'b1;
		end
		if (lst)
			clear_window();
		return got;
	endfunction

	function automatic void expect_byte(logic [7:0] b, bit rd, bit lst);
		result_t r;
		if (scan_byte(b, rd, lst, r))
			pending_results.push_back(r);
	endfunction

	function automatic stim_row_t cfg_row(cfg_reg_t idx, logic [CFG_W-1:0] v);
		stim_row_t r;
		r.kind     = ROW_CFG;
		r.reg_idx  = idx;
		r.value    = v;
		r.data     = 8'h00;
		r.readable = 1'b0;
		r.last     = 1'b0;
		r.want     = '0;
		return r;
	endfunction

	function automatic stim_row_t byte_row(row_kind_t kind, logic [7:0] b, bit rd, bit lst,
			bit found, logic [ADDR_W-1:0] addr);
		stim_row_t r;
		r = cfg_row(REG_PAT_LO, '0);
		r.kind               = kind;
		r.data               = b;
		r.readable           = rd;
		r.last               = lst;
		r.want.found         = found;
		r.want.match_address = addr;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
			input logic [ADDR_W-1:0] want);
		errors++;
		if (errors <= 30)
			$display("error at %0t ns: %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// drop the write enable after a group of register writes
	task automatic release_cfg();
		if (cfg_busy) begin
			cfg_wen  <= 1'b0;
			cfg_busy = 1'b0;
		end
	endtask

	// offer one byte, with random gaps, until the request is taken
	task automatic push_byte(input logic [7:0] b, input bit rd, input bit lst);
		release_cfg();
		calm = (bytes_sent >= 500 && bytes_sent < 800);
		while (!calm && $urandom_range(0, 99) < 7) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= rd;
		s_axis_tlast  <= lst;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
		if (lst)
			scans_ended++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		set_reg(idx, v);
		cfg_busy = 1'b1;
	endtask

	// hold off the sender until every result is in and the pipeline has settled
	task automatic drain_results();
		release_cfg();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one register setting followed by a stream of scans
	task automatic run_phase(input int budget);
		int n;
		int k;
		int at;
		int scan_len;
		int sent;
		bit narrow;
		bit noise;
		bit planted;
		bit rd;
		bit lst;
		logic [7:0] b;
		logic [CFG_W-1:0] lo;
		logic [CFG_W-1:0] hi;
		logic [MASK_W-1:0] wm;
		logic [LEN_W-1:0] len;
		logic [ADDR_W-1:0] base;
		drain_results();
		// narrow phases draw pattern and data from two bytes so matches come often
		narrow = ($urandom_range(0, 2) == 0);
		if (narrow) begin
			for (k = 0; k < 8; k++) begin
				lo[k*8 +: 8] = $urandom_range(0, 1) ? 8'h2A : 8'h3F;
				hi[k*8 +: 8] = $urandom_range(0, 1) ? 8'h2A : 8'h3F;
			end
		end else begin
			case ($urandom_range(0, 5))
				0: begin
					lo = '0;
					hi = '0;
				end
				1: begin
					lo = '1;
					hi = '1;
				end
				default: begin
					lo = {$urandom, $urandom};
					hi = {$urandom, $urandom};
				end
			endcase
		end
		case ($urandom_range(0, 7))
			0:       wm = '0;
			1:       wm = '1;
			default: wm = MASK_W'($urandom & $urandom);
		endcase
		case ($urandom_range(0, 9))
			0:       len = '0;
			1:       len = LEN_W'($urandom_range(17, 31));
			2:       len = LEN_W'(16);
			3:       len = LEN_W'(1);
			default: len = LEN_W'($urandom_range(1, narrow ? 4 : 16));
		endcase
		case ($urandom_range(0, 3))
			0:       base = '0;
			1:       base = {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 40));
			default: base = ADDR_W'({$urandom, $urandom});
		endcase
		write_reg(REG_PAT_LO, lo);
		write_reg(REG_PAT_HI, hi);
		write_reg(REG_MASK, CFG_W'(wm));
		write_reg(REG_LEN, CFG_W'(len));
		write_reg(REG_BASE, CFG_W'(base));
		settings_used++;
		n = used_len();
		sent = 0;
		while (sent < budget) begin
			scan_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
			noise    = ($urandom_range(0, 3) == 0);
			planted  = !noise && scan_len >= n;
			at       = planted ? $urandom_range(0, scan_len - n) : 0;
			for (k = 0; k < scan_len; k++) begin
				b  = narrow ? ($urandom_range(0, 1) ? 8'h2A : 8'h3F) : 8'($urandom_range(0, 255));
				rd = noise ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 33) != 0);
				if (planted && k >= at && k < at + n && !wm[k-at])
					b = sig_bytes[(k-at)*8 +: 8];
				lst = (k == scan_len - 1);
				// sometimes the scan runs on across the next register change
				if (lst && sent + scan_len >= budget && $urandom_range(0, 3) == 0)
					lst = 1'b0;
				push_byte(b, rd, lst);
				expect_byte(b, rd, lst);
			end
			sent += scan_len;
		end
	endtask

	// result side: check each request against the oldest expectation, stall at random
	initial begin : result_check
		result_t want;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with none expected", m_axis_tdata, '0);
				end else begin
					want = pending_results.pop_front();
					if (m_axis_tuser !== want.found)
						report_mismatch("found flag", ADDR_W'(m_axis_tuser), ADDR_W'(want.found));
					if (m_axis_tdata !== want.match_address)
						report_mismatch("match address", m_axis_tdata, want.match_address);
					if (want.found)
						hits_seen++;
					else
						misses_seen++;
				end
			end
			m_axis_tready <= calm || ($urandom_range(0, 99) >= 7);
		end
	end

	initial begin : stimulus
		stim_row_t rows[$];
		result_t unused;
		int i;
		int directed_bytes;
		int settle;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 8'h00;
		s_axis_tuser  <= 1'b0;
		s_axis_tlast  <= 1'b0;
		cfg_wen       <= 1'b0;
		cfg_index     <= REG_PAT_LO;
		cfg_wdata     <= '0;
		clear_window();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: one zero byte; bytes after a match; unreadable end of scan
		rows.push_back(byte_row(ROW_HIT, 8'h00, 1'b1, 1'b0, 1'b1, 48'h0));
		rows.push_back(byte_row(ROW_QUIET, 8'hFF, 1'b1, 1'b1, 1'b0, 48'h0));
		rows.push_back(byte_row(ROW_HIT, 8'h00, 1'b0, 1'b1, 1'b0, 48'h0));
		// length zero acts as one, match on the last byte at the top address
		rows.push_back(cfg_row(REG_LEN, 64'd0));
		rows.push_back(cfg_row(REG_PAT_LO, {CFG_W{1'b1}}));
		rows.push_back(cfg_row(REG_BASE, 64'hFFFF_FFFF_FFFF));
		rows.push_back(byte_row(ROW_HIT, 8'hFF, 1'b1, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF));
		// literal star and question mark bytes are plain signature bytes
		rows.push_back(cfg_row(REG_LEN, 64'd2));
		rows.push_back(cfg_row(REG_PAT_LO, 64'h3F2A));
		rows.push_back(cfg_row(REG_BASE, 64'h100));
		rows.push_back(byte_row(ROW_QUIET, 8'h3F, 1'b1, 1'b0, 1'b0, 48'h0));
		rows.push_back(byte_row(ROW_QUIET, 8'h2A, 1'b1, 1'b0, 1'b0, 48'h0));
		rows.push_back(byte_row(ROW_HIT, 8'h3F, 1'b1, 1'b1, 1'b1, 48'h101));
		// oversize length saturates, all wildcards, unreadable byte blocks the window,
		// match address wraps past the top
		rows.push_back(cfg_row(REG_LEN, 64'd31));
		rows.push_back(cfg_row(REG_MASK, 64'hFFFF));
		rows.push_back(cfg_row(REG_PAT_HI, {CFG_W{1'b1}}));
		rows.push_back(cfg_row(REG_BASE, 64'hFFFF_FFFF_FFFF));
		rows.push_back(byte_row(ROW_BYTE, 8'h5A, 1'b0, 1'b0, 1'b0, 48'h0));
		for (i = 0; i < 15; i++)
			rows.push_back(byte_row(ROW_BYTE, 8'(i * 17), 1'b1, 1'b0, 1'b0, 48'h0));
		rows.push_back(byte_row(ROW_HIT, 8'hA5, 1'b1, 1'b1, 1'b1, 48'h0));

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				if (!cfg_busy)
					drain_results();
				write_reg(rows[i].reg_idx, rows[i].value);
			end else begin
				push_byte(rows[i].data, rows[i].readable, rows[i].last);
				if (rows[i].kind == ROW_BYTE) begin
					expect_byte(rows[i].data, rows[i].readable, rows[i].last);
				end else begin
					void'(scan_byte(rows[i].data, rows[i].readable, rows[i].last, unused));
					if (rows[i].kind == ROW_HIT)
						pending_results.push_back(rows[i].want);
				end
			end
		end
		settings_used = 4;
		directed_bytes = bytes_sent;

		// random part: fresh register setting every phase
		while (bytes_sent - directed_bytes < RANDOM_BYTES)
			run_phase($urandom_range(60, 140));

		s_axis_tvalid <= 1'b0;
		for (settle = 0; settle < 10000 && pending_results.size() != 0; settle++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", '0, ADDR_W'(pending_results.size()));

		$display("scanned %0d bytes in %0d regions under %0d register settings",
			bytes_sent, scans_ended, settings_used);
		$display("checked %0d matches and %0d not-found results, %0d errors",
			hits_seen, misses_seen, errors);
		if (errors == 0)
			$display("wildcard_byte_signature_scan_unit: match");
		else
			$display("wildcard_byte_signature_scan_unit: mismatch");
		$finish;
	end

	// overall time limit
	initial begin
		#5000000;
		$display("timeout at %0t ns", $time);
		$display("wildcard_byte_signature_scan_unit: mismatch");
		$finish;
	end

endmodule
